// ----- rtl/tnsa_pkg.sv -----
`timescale 1ns / 1ps
package tnsa_pkg;

	localparam int MAX_SLOTS = 8;
	localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam int CMD_W  = 2;
	localparam int TRK_W  = 4;
	localparam int KEY_W  = 7;
	localparam int VEL_W  = 8;
	localparam int DUR_W  = 32;
	localparam int VOL_W  = 9;
	localparam int PAN_W  = 8;
	localparam int FRM_W  = 16;
	localparam int CODE_W = 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_NOTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CODE_W-1:0] CODE_NONE  = 8'hFF;
	localparam logic [CODE_W-1:0] VOL_RESET  = 8'd127;
	localparam logic [PAN_W-1:0]  PAN_BIAS   = 8'd64;

	localparam logic KIND_OFF = 1'b0;
	localparam logic KIND_ON  = 1'b1;

	// register index = paddr[2]
	localparam logic REG_MAX_VOLUME = 1'b0;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SCAN,
		OP_PUSH_REL,
		OP_PUSH_VICTIM,
		OP_PUSH_ON,
		OP_DROP_HIT,
		OP_TICK_STEP,
		OP_PUSH_TMP,
		OP_DROP_IDX,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		logic [CMD_W-1:0] new_cmd;
		logic             scan_end;
		logic             hit;
		logic             vel_zero;
		logic             dur_zero;
		logic             full;
		logic             expire;
		logic             can_emit;
		logic             pend_valid;
		logic             count_nz;
	} dp_stat_t;

	typedef struct packed {
		logic              kind;
		logic [TRK_W-1:0]  trk;
		logic [KEY_W-1:0]  key;
		logic [VEL_W-1:0]  vel;
		logic [CODE_W-1:0] vol;
		logic [CODE_W-1:0] pan;
	} event_t;

endpackage

// ----- rtl/tnsa_ctrl.sv -----
`timescale 1ns / 1ps
module tnsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tnsa_pkg::dp_stat_t st,
	output tnsa_pkg::dp_op_t  op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_REL_EMIT,
		S_REL_DROP,
		S_OFF_EMIT,
		S_ON_EMIT,
		S_TICK_CHK,
		S_TICK_EMIT,
		S_TICK_DROP,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		op        = tnsa_pkg::OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = tnsa_pkg::OP_LOAD;
					if (st.new_cmd == tnsa_pkg::CMD_NOTE) begin
						state_nxt = S_SCAN;
					end else if (st.new_cmd == tnsa_pkg::CMD_TICK) begin
						state_nxt = S_TICK_CHK;
					end
				end
			end
			S_SCAN: begin
				op = tnsa_pkg::OP_SCAN;
				if (st.scan_end || st.hit) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (st.vel_zero) begin
					state_nxt = st.hit ? S_REL_EMIT : S_FLUSH;
				end else if (st.dur_zero) begin
					state_nxt = S_FLUSH;
				end else if (!st.hit && !st.full) begin
					state_nxt = S_ON_EMIT;
				end else begin
					state_nxt = S_OFF_EMIT;
				end
			end
			S_REL_EMIT: begin
				if (st.can_emit) begin
					op        = tnsa_pkg::OP_PUSH_REL;
					state_nxt = S_REL_DROP;
				end
			end
			S_REL_DROP: begin
				op        = tnsa_pkg::OP_DROP_HIT;
				state_nxt = S_FLUSH;
			end
			S_OFF_EMIT: begin
				if (st.can_emit) begin
					op        = tnsa_pkg::OP_PUSH_VICTIM;
					state_nxt = S_ON_EMIT;
				end
			end
			S_ON_EMIT: begin
				if (st.can_emit) begin
					op        = tnsa_pkg::OP_PUSH_ON;
					state_nxt = S_FLUSH;
				end
			end
			S_TICK_CHK: begin
				if (st.scan_end) begin
					state_nxt = S_FLUSH;
				end else begin
					op = tnsa_pkg::OP_TICK_STEP;
					if (st.expire) begin
						state_nxt = S_TICK_EMIT;
					end
				end
			end
			S_TICK_EMIT: begin
				if (st.can_emit) begin
					op        = tnsa_pkg::OP_PUSH_TMP;
					state_nxt = S_TICK_DROP;
				end
			end
			S_TICK_DROP: begin
				op        = tnsa_pkg::OP_DROP_IDX;
				state_nxt = S_TICK_CHK;
			end
			S_FLUSH: begin
				if (st.can_emit) begin
					op        = tnsa_pkg::OP_FLUSH;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// nothing may be left staged once an item is done
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !st.pend_valid)
		else $error("staged event left behind in idle");

	a_rel_drop_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REL_DROP |-> st.hit && st.count_nz)
		else $error("release drop without a matching entry");

	a_tick_drop_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK_DROP |-> st.count_nz)
		else $error("expiry drop on empty table");

endmodule

// ----- rtl/tnsa_dp.sv -----
`timescale 1ns / 1ps
module tnsa_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tnsa_pkg::dp_op_t                     op,
	output tnsa_pkg::dp_stat_t                   st,
	input  logic [tnsa_pkg::CODE_W-1:0]          max_volume,
	input  logic [tnsa_pkg::CMD_W-1:0]           cmd,
	input  logic [tnsa_pkg::TRK_W-1:0]           track,
	input  logic [tnsa_pkg::KEY_W-1:0]           note_key,
	input  logic [tnsa_pkg::VEL_W-1:0]           velocity,
	input  logic [tnsa_pkg::DUR_W-1:0]           duration,
	input  logic signed [tnsa_pkg::VOL_W-1:0]    raw_volume,
	input  logic signed [tnsa_pkg::PAN_W-1:0]    pan_req,
	input  logic [tnsa_pkg::FRM_W-1:0]           frames,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output tnsa_pkg::event_t                     out_ev,
	output logic                                 out_last
);

	// item fields, latched on load
	logic [tnsa_pkg::CMD_W-1:0]  cmd_q;
	logic [tnsa_pkg::TRK_W-1:0]  trk_q;
	logic [tnsa_pkg::KEY_W-1:0]  key_q;
	logic [tnsa_pkg::VEL_W-1:0]  vel_q;
	logic [tnsa_pkg::DUR_W-1:0]  dur_q;
	logic [tnsa_pkg::VOL_W-1:0]  vol_q;
	logic [tnsa_pkg::PAN_W-1:0]  pan_q;
	logic [tnsa_pkg::FRM_W-1:0]  frm_q;

	// slot table
	logic [tnsa_pkg::TRK_W-1:0] slot_track_q     [tnsa_pkg::MAX_SLOTS];
	logic [tnsa_pkg::KEY_W-1:0] slot_key_q       [tnsa_pkg::MAX_SLOTS];
	logic [tnsa_pkg::DUR_W-1:0] slot_remaining_q [tnsa_pkg::MAX_SLOTS];

	logic [tnsa_pkg::CNT_W-1:0] count_q;
	logic [tnsa_pkg::CNT_W-1:0] idx_q;
	logic                       hit_q;
	logic [tnsa_pkg::IDX_W-1:0] hit_idx_q;
	logic [tnsa_pkg::IDX_W-1:0] min_idx_q;
	logic [tnsa_pkg::DUR_W-1:0] min_rem_q;
	logic [tnsa_pkg::TRK_W-1:0] min_trk_q;
	logic [tnsa_pkg::KEY_W-1:0] min_key_q;
	logic [tnsa_pkg::TRK_W-1:0] tmp_trk_q;
	logic [tnsa_pkg::KEY_W-1:0] tmp_key_q;

	logic             pend_valid_q;
	tnsa_pkg::event_t pend_ev_q;
	logic             out_valid_q;
	tnsa_pkg::event_t out_ev_q;
	logic             out_last_q;

	logic [tnsa_pkg::CNT_W-1:0] cnt_m1;
	logic [tnsa_pkg::IDX_W-1:0] idx;
	logic [tnsa_pkg::IDX_W-1:0] rd_addr;
	logic [tnsa_pkg::IDX_W-1:0] on_idx;
	logic [tnsa_pkg::TRK_W-1:0] rd_trk;
	logic [tnsa_pkg::KEY_W-1:0] rd_key;
	logic [tnsa_pkg::DUR_W-1:0] rd_rem;
	logic                       is_drop;
	logic                       push;
	logic                       out_load;
	logic                       scan_end;
	logic                       full;
	logic                       match;
	logic                       expire;
	logic                       can_emit;
	logic [tnsa_pkg::CODE_W-1:0] vol_code;
	logic [tnsa_pkg::CODE_W-1:0] pan_code;
	tnsa_pkg::event_t           ev_new;

	assign cnt_m1  = count_q - tnsa_pkg::CNT_W'(1);
	assign idx     = idx_q[tnsa_pkg::IDX_W-1:0];
	assign is_drop = (op == tnsa_pkg::OP_DROP_HIT) || (op == tnsa_pkg::OP_DROP_IDX);
	assign rd_addr = is_drop ? cnt_m1[tnsa_pkg::IDX_W-1:0] : idx;
	assign rd_trk  = slot_track_q[rd_addr];
	assign rd_key  = slot_key_q[rd_addr];
	assign rd_rem  = slot_remaining_q[rd_addr];

	assign scan_end = (idx_q >= count_q);
	assign full     = (count_q == tnsa_pkg::CNT_W'(tnsa_pkg::MAX_SLOTS));
	assign match    = (rd_trk == trk_q) && (rd_key == key_q);
	assign expire   = (rd_rem <= tnsa_pkg::DUR_W'(frm_q));
	assign can_emit = !pend_valid_q || !out_valid_q || out_ready;
	assign on_idx   = hit_q ? hit_idx_q : (full ? min_idx_q : count_q[tnsa_pkg::IDX_W-1:0]);

	// byte codes: sign bit of volume, or pan outside -64..63, means leave
	assign vol_code = vol_q[tnsa_pkg::VOL_W-1] ? tnsa_pkg::CODE_NONE :
		((vol_q[tnsa_pkg::CODE_W-1:0] < max_volume) ? vol_q[tnsa_pkg::CODE_W-1:0] : max_volume);
	assign pan_code = (pan_q[tnsa_pkg::PAN_W-1] == pan_q[tnsa_pkg::PAN_W-2]) ?
		(pan_q + tnsa_pkg::PAN_BIAS) : tnsa_pkg::CODE_NONE;

	always_comb begin
		ev_new.kind = tnsa_pkg::KIND_OFF;
		ev_new.trk  = tmp_trk_q;
		ev_new.key  = tmp_key_q;
		ev_new.vel  = '0;
		ev_new.vol  = tnsa_pkg::CODE_NONE;
		ev_new.pan  = tnsa_pkg::CODE_NONE;
		push        = 1'b0;
		case (op)
			tnsa_pkg::OP_PUSH_REL: begin
				push       = 1'b1;
				ev_new.trk = trk_q;
				ev_new.key = key_q;
			end
			tnsa_pkg::OP_PUSH_VICTIM: begin
				push       = 1'b1;
				ev_new.trk = hit_q ? trk_q : min_trk_q;
				ev_new.key = hit_q ? key_q : min_key_q;
			end
			tnsa_pkg::OP_PUSH_ON: begin
				push        = 1'b1;
				ev_new.kind = tnsa_pkg::KIND_ON;
				ev_new.trk  = trk_q;
				ev_new.key  = key_q;
				ev_new.vel  = vel_q;
				ev_new.vol  = vol_code;
				ev_new.pan  = pan_code;
			end
			tnsa_pkg::OP_PUSH_TMP: begin
				push = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// staged event goes out once the next one (or the end) is known
	assign out_load = (push || (op == tnsa_pkg::OP_FLUSH)) && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (op)
				tnsa_pkg::OP_LOAD: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					if (cmd == tnsa_pkg::CMD_CLEAR) begin
						count_q <= '0;
					end
				end
				tnsa_pkg::OP_SCAN: begin
					if (!scan_end && !hit_q) begin
						idx_q <= idx_q + tnsa_pkg::CNT_W'(1);
						if (match) begin
							hit_q <= 1'b1;
						end
					end
				end
				tnsa_pkg::OP_PUSH_ON: begin
					if (!hit_q && !full) begin
						count_q <= count_q + tnsa_pkg::CNT_W'(1);
					end
				end
				tnsa_pkg::OP_TICK_STEP: begin
					if (!expire) begin
						idx_q <= idx_q + tnsa_pkg::CNT_W'(1);
					end
				end
				tnsa_pkg::OP_DROP_HIT, tnsa_pkg::OP_DROP_IDX: begin
					count_q <= cnt_m1;
				end
				default: begin
				end
			endcase

			if (push) begin
				pend_valid_q <= 1'b1;
			end else if (op == tnsa_pkg::OP_FLUSH) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and table, no reset
	always_ff @(posedge clk) begin
		if (op == tnsa_pkg::OP_LOAD) begin
			cmd_q <= cmd;
			trk_q <= track;
			key_q <= note_key;
			vel_q <= velocity;
			dur_q <= duration;
			vol_q <= raw_volume;
			pan_q <= pan_req;
			frm_q <= frames;
		end
		if (op == tnsa_pkg::OP_SCAN && !scan_end && !hit_q) begin
			if (match) begin
				hit_idx_q <= idx;
			end
			if (idx_q == '0 || rd_rem < min_rem_q) begin
				min_idx_q <= idx;
				min_rem_q <= rd_rem;
				min_trk_q <= rd_trk;
				min_key_q <= rd_key;
			end
		end
		case (op)
			tnsa_pkg::OP_PUSH_ON: begin
				slot_track_q[on_idx]     <= trk_q;
				slot_key_q[on_idx]       <= key_q;
				slot_remaining_q[on_idx] <= dur_q;
			end
			tnsa_pkg::OP_DROP_HIT: begin
				slot_track_q[hit_idx_q]     <= rd_trk;
				slot_key_q[hit_idx_q]       <= rd_key;
				slot_remaining_q[hit_idx_q] <= rd_rem;
			end
			tnsa_pkg::OP_DROP_IDX: begin
				slot_track_q[idx]     <= rd_trk;
				slot_key_q[idx]       <= rd_key;
				slot_remaining_q[idx] <= rd_rem;
			end
			tnsa_pkg::OP_TICK_STEP: begin
				if (expire) begin
					tmp_trk_q <= rd_trk;
					tmp_key_q <= rd_key;
				end else begin
					slot_remaining_q[idx] <= rd_rem - tnsa_pkg::DUR_W'(frm_q);
				end
			end
			default: begin
			end
		endcase
		if (push) begin
			pend_ev_q <= ev_new;
		end
		if (out_load) begin
			out_ev_q   <= pend_ev_q;
			out_last_q <= (op == tnsa_pkg::OP_FLUSH);
		end
	end

	assign out_valid = out_valid_q;
	assign out_ev    = out_ev_q;
	assign out_last  = out_last_q;

	assign st.new_cmd    = cmd;
	assign st.scan_end   = scan_end;
	assign st.hit        = hit_q;
	assign st.vel_zero   = (vel_q == '0);
	assign st.dur_zero   = (dur_q == '0) || (cmd_q != tnsa_pkg::CMD_NOTE);
	assign st.full       = full;
	assign st.expire     = expire;
	assign st.can_emit   = can_emit;
	assign st.pend_valid = pend_valid_q;
	assign st.count_nz   = (count_q != '0);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tnsa_pkg::CNT_W'(tnsa_pkg::MAX_SLOTS))
		else $error("slot count beyond table size");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_emit)
		else $error("event pushed while stage and output are both held");

	a_drop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		is_drop |=> count_q == $past(count_q) - tnsa_pkg::CNT_W'(1))
		else $error("drop did not shrink the table");

endmodule

// ----- rtl/timed_note_slot_allocator.sv -----
`timescale 1ns / 1ps
// Sequence: a note scans up to 8 entries until a match, then emits its events, plus a drop
//   on a release; a tick emits and drops each expired entry; clear/unused only load.
// Items: one at a time, each taken the cycle after the previous item's last step;
//   an emit or flush step waits while the output is stalled.
// Reset (arst_n low, async): table empty, no staged or pending beat, max_volume = 127;
//   slot contents are left as they are and never read before written.
module timed_note_slot_allocator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// config port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tnsa_pkg::PADDR_W-1:0]           paddr,
	input  logic [tnsa_pkg::PDATA_W-1:0]           pwdata,
	output logic [tnsa_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready,
	// input beats
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [tnsa_pkg::CMD_W-1:0]             cmd,
	input  logic [tnsa_pkg::TRK_W-1:0]             track,
	input  logic [tnsa_pkg::KEY_W-1:0]             note_key,
	input  logic [tnsa_pkg::VEL_W-1:0]             velocity,
	input  logic [tnsa_pkg::DUR_W-1:0]             duration,
	input  logic signed [tnsa_pkg::VOL_W-1:0]      raw_volume,
	input  logic signed [tnsa_pkg::PAN_W-1:0]      pan_req,
	input  logic [tnsa_pkg::FRM_W-1:0]             frames,
	// output beats
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   event_kind,
	output logic [tnsa_pkg::TRK_W-1:0]             out_track,
	output logic [tnsa_pkg::KEY_W-1:0]             out_key,
	output logic [tnsa_pkg::VEL_W-1:0]             out_velocity,
	output logic [tnsa_pkg::CODE_W-1:0]           volume_code,
	output logic [tnsa_pkg::CODE_W-1:0]           pan_code,
	output logic                                   last
);

	logic [tnsa_pkg::CODE_W-1:0] max_volume_q;
	logic                        reg_sel;
	logic                        cfg_wr;

	tnsa_pkg::dp_op_t   op;
	tnsa_pkg::dp_stat_t st;
	tnsa_pkg::event_t   ev;

	// Register map: word index in paddr[2], only max_volume exists.
	// Writes land on the access phase; writes past the map are dropped.
	assign pready  = 1'b1;
	assign reg_sel = paddr[tnsa_pkg::PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && (reg_sel == tnsa_pkg::REG_MAX_VOLUME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_volume_q <= tnsa_pkg::VOL_RESET;
		end else if (cfg_wr) begin
			max_volume_q <= pwdata[tnsa_pkg::CODE_W-1:0];
		end
	end

	// readback: zero-extended register, zero outside the map
	always_comb begin
		unique case (reg_sel)
			tnsa_pkg::REG_MAX_VOLUME: prdata = tnsa_pkg::PDATA_W'(max_volume_q);
			default:                  prdata = '0;
		endcase
	end

	// Controller sequences scan / emit / drop steps; it sees only in_valid and status bits.
	tnsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	// Datapath: slot table, scan index, min tracker, one staged event plus
	// the output register. The staged event is released with last=0 when the
	// next event arrives, or with last=1 at the end of the item, so a tick
	// knows which expiry is final without a lookahead scan.
	tnsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.st         (st),
		.max_volume (max_volume_q),
		.cmd        (cmd),
		.track      (track),
		.note_key   (note_key),
		.velocity   (velocity),
		.duration   (duration),
		.raw_volume (raw_volume),
		.pan_req    (pan_req),
		.frames     (frames),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_ev     (ev),
		.out_last   (last)
	);

	assign event_kind   = ev.kind;
	assign out_track    = ev.trk;
	assign out_key      = ev.key;
	assign out_velocity = ev.vel;
	assign volume_code  = ev.vol;
	assign pan_code     = ev.pan;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import tnsa_pkg::*;

	// cmd code 3 is not decoded by the block; it must be swallowed silently
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// byte address of max_volume on the config port
	localparam logic [PADDR_W-1:0] MAX_VOLUME_ADDR = {REG_MAX_VOLUME, 2'b00};

	// worst case busy time is a tick over a full table that expires every entry;
	// the settle wait is rounded up from it
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 36;
	localparam int RANDOM_PHASES  = 8;

	// one input beat, all fields at port widths
	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [TRK_W-1:0]        trk;
		logic [KEY_W-1:0]        key;
		logic [VEL_W-1:0]        vel;
		logic [DUR_W-1:0]        dur;
		logic signed [VOL_W-1:0] vol;
		logic signed [PAN_W-1:0] pan;
		logic [FRM_W-1:0]        frm;
	} note_req_t;

	// one output beat as the block should present it
	typedef struct packed {
		event_t ev;
		logic   last;
	} note_event_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [CMD_W-1:0]          cmd = '0;
	logic [TRK_W-1:0]          track = '0;
	logic [KEY_W-1:0]          note_key = '0;
	logic [VEL_W-1:0]          velocity = '0;
	logic [DUR_W-1:0]          duration = '0;
	logic signed [VOL_W-1:0]   raw_volume = '0;
	logic signed [PAN_W-1:0]   pan_req = '0;
	logic [FRM_W-1:0]          frames = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b1;
	logic                      event_kind;
	logic [TRK_W-1:0]          out_track;
	logic [KEY_W-1:0]          out_key;
	logic [VEL_W-1:0]          out_velocity;
	logic [CODE_W-1:0]         volume_code;
	logic [CODE_W-1:0]         pan_code;
	logic                      last;

	// shadow copy of the slot table and the register
	logic [TRK_W-1:0] slot_trk [MAX_SLOTS];
	logic [KEY_W-1:0] slot_key [MAX_SLOTS];
	logic [DUR_W-1:0] slot_left [MAX_SLOTS];
	int               live_slots = 0;
	logic [7:0]       vol_limit = VOL_RESET;

	note_event_t pending_events[$];
	note_event_t event_due;
	int          err_count = 0;
	int          quiet_cycles = 0;

	// traffic shaping knobs
	logic steady = 1'b0;   // no idling on either side
	int   gap_pct = 30;    // chance of a sender gap before a beat
	int   stall_pct = 20;  // chance of a receiver stall burst
	int   stall_left = 0;
	int   stall_epoch = 0;

	timed_note_slot_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.track(track),
		.note_key(note_key),
		.velocity(velocity),
		.duration(duration),
		.raw_volume(raw_volume),
		.pan_req(pan_req),
		.frames(frames),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.out_track(out_track),
		.out_key(out_key),
		.out_velocity(out_velocity),
		.volume_code(volume_code),
		.pan_code(pan_code),
		.last(last)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Slot table predictor
	// ---------------------------------------------------------------

	// note-offs never carry volume or pan: both read as "leave"
	function automatic note_event_t off_event(input logic [TRK_W-1:0] trk,
			input logic [KEY_W-1:0] key);
		note_event_t e;
		e = '0;
		e.ev.kind = KIND_OFF;
		e.ev.trk  = trk;
		e.ev.key  = key;
		e.ev.vol  = CODE_NONE;
		e.ev.pan  = CODE_NONE;
		return e;
	endfunction

	// note-on: negative volume means leave, else clamp to max_volume;
	// pan outside -64..63 means leave, else bias into 0..127
	function automatic note_event_t on_event(input note_req_t r);
		note_event_t e;
		e = '0;
		e.ev.kind = KIND_ON;
		e.ev.trk  = r.trk;
		e.ev.key  = r.key;
		e.ev.vel  = r.vel;
		if (r.vol[VOL_W-1])
			e.ev.vol = CODE_NONE;
		else
			e.ev.vol = (r.vol[7:0] < vol_limit) ? r.vol[7:0] : vol_limit;
		if (r.pan < -64 || r.pan > 63)
			e.ev.pan = CODE_NONE;
		else
			e.ev.pan = r.pan + PAN_BIAS;
		return e;
	endfunction

	// compacted table: the last live entry moves into the hole
	task automatic vacate_slot(input int idx);
		live_slots--;
		slot_trk[idx]  = slot_trk[live_slots];
		slot_key[idx]  = slot_key[live_slots];
		slot_left[idx] = slot_left[live_slots];
	endtask

	task automatic predict_slot_table(input note_req_t r);
		note_event_t fresh[$];
		note_event_t e;
		int hit;
		int slot;
		int i;
		hit = -1;
		case (r.cmd)
			CMD_NOTE: begin
				for (i = 0; i < live_slots; i++)
					if (hit < 0 && slot_trk[i] == r.trk && slot_key[i] == r.key)
						hit = i;
				if (r.vel == 0) begin
					// early release; a miss is silent
					if (hit >= 0) begin
						fresh.push_back(off_event(r.trk, r.key));
						vacate_slot(hit);
					end
				end else if (r.dur != 0) begin
					slot = hit;
					if (hit < 0 && live_slots < MAX_SLOTS) begin
						slot = live_slots;
						live_slots++;
					end else begin
						// a hit is turned off first; a full table steals the first entry with least time left
						if (hit < 0) begin
							slot = 0;
							for (i = 1; i < live_slots; i++)
								if (slot_left[i] < slot_left[slot])
									slot = i;
						end
						fresh.push_back(off_event(slot_trk[slot], slot_key[slot]));
					end
					fresh.push_back(on_event(r));
					slot_trk[slot]  = r.trk;
					slot_key[slot]  = r.key;
					slot_left[slot] = r.dur;
				end
			end
			CMD_TICK: begin
				// expire in table order; the swapped-in entry is looked at next
				i = 0;
				while (i < live_slots) begin
					if (slot_left[i] <= r.frm) begin
						fresh.push_back(off_event(slot_trk[i], slot_key[i]));
						vacate_slot(i);
					end else begin
						slot_left[i] = slot_left[i] - r.frm;
						i++;
					end
				end
			end
			CMD_CLEAR: live_slots = 0;
			default: ;
		endcase
		for (i = 0; i < fresh.size(); i++) begin
			e = fresh[i];
			e.last = (i == fresh.size() - 1);
			pending_events.push_back(e);
		end
	endtask

	// ---------------------------------------------------------------
	// Beat builders
	// ---------------------------------------------------------------

	// every field random, volume kept in -1..255
	function automatic note_req_t noise_fields();
		note_req_t r;
		r.cmd = CMD_W'($urandom_range(3));
		r.trk = TRK_W'($urandom);
		r.key = KEY_W'($urandom);
		r.vel = VEL_W'($urandom);
		r.dur = $urandom;
		r.vol = VOL_W'($urandom_range(256)) - 9'd1;
		r.pan = PAN_W'($urandom);
		r.frm = FRM_W'($urandom);
		return r;
	endfunction

	function automatic note_req_t req_play(input logic [TRK_W-1:0] trk,
			input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel,
			input logic [DUR_W-1:0] dur, input logic signed [VOL_W-1:0] vol,
			input logic signed [PAN_W-1:0] pan);
		note_req_t r;
		r = noise_fields();
		r.cmd = CMD_NOTE;
		r.trk = trk;
		r.key = key;
		r.vel = vel;
		r.dur = dur;
		r.vol = vol;
		r.pan = pan;
		return r;
	endfunction

	function automatic note_req_t req_release(input logic [TRK_W-1:0] trk,
			input logic [KEY_W-1:0] key);
		note_req_t r;
		r = noise_fields();
		r.cmd = CMD_NOTE;
		r.trk = trk;
		r.key = key;
		r.vel = '0;
		return r;
	endfunction

	function automatic note_req_t req_tick(input logic [FRM_W-1:0] frm);
		note_req_t r;
		r = noise_fields();
		r.cmd = CMD_TICK;
		r.frm = frm;
		return r;
	endfunction

	function automatic note_req_t req_plain(input logic [CMD_W-1:0] code);
		note_req_t r;
		r = noise_fields();
		r.cmd = code;
		return r;
	endfunction

	// mostly note-ons and ticks on a small pool of track/key pairs so that
	// retriggers, releases, steals and multi-entry expiries keep happening
	function automatic note_req_t random_req();
		note_req_t r;
		int roll;
		r = noise_fields();
		if ($urandom_range(99) < 70) begin
			r.trk = TRK_W'($urandom_range(3));
			r.key = KEY_W'($urandom_range(67, 60));
		end
		roll = $urandom_range(99);
		if (roll < 50) begin
			r.cmd = CMD_NOTE;
			if (r.vel == 0)
				r.vel = 8'd1;
			case ($urandom_range(19))
				0: r.dur = 32'hFFFF_FFFF;
				1: r.dur = 32'd1;
				2, 3: r.dur = $urandom;
				4, 5: r.dur = $urandom_range(65535);
				default: r.dur = $urandom_range(3000, 1);
			endcase
		end else if (roll < 64) begin
			r.cmd = CMD_NOTE;
			r.vel = '0;
		end else if (roll < 90) begin
			r.cmd = CMD_TICK;
			case ($urandom_range(9))
				0: r.frm = '0;
				1: r.frm = '1;
				2: r.frm = FRM_W'($urandom);
				default: r.frm = FRM_W'($urandom_range(1200));
			endcase
		end else if (roll < 93) begin
			r.cmd = CMD_CLEAR;
		end else if (roll < 96) begin
			r.cmd = CMD_UNUSED;
		end else begin
			// zero duration; with velocity 0 this is a plain release
			r.cmd = CMD_NOTE;
			r.dur = '0;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Drivers. Every task starts and ends in the time step of a rising edge.
	// ---------------------------------------------------------------

	// one input beat; prediction runs at the accepting edge
	task automatic send_req(input note_req_t r);
		if (!steady && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= r.cmd;
		track      <= r.trk;
		note_key   <= r.key;
		velocity   <= r.vel;
		duration   <= r.dur;
		raw_volume <= r.vol;
		pan_req    <= r.pan;
		frames     <= r.frm;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predict_slot_table(r);
	endtask

	// hold off the sender until every expected beat is out; the queue is
	// looked at on the falling edge so the monitor has already popped
	task automatic drain_events();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_events.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// write max_volume while idle, then read it back
	task automatic set_max_volume(input logic [7:0] level);
		drain_events();
		// a clear or an ignored beat leaves nothing in the queue but may
		// still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MAX_VOLUME_ADDR;
		pwdata  <= {24'd0, level};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		vol_limit = level;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", {24'd0, level}, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------

	// field extremes and every volume/pan encoding on the reset register value
	task automatic test_note_fields();
		send_req(req_play(4'd0, 7'd0, 8'd1, 32'd1, 9'sd0, -8'sd64));
		send_req(req_play(4'd15, 7'd127, 8'd255, 32'hFFFF_FFFF, 9'sd255, 8'sd63));
		send_req(req_play(4'd7, 7'd64, 8'd128, 32'd1000, -9'sd1, -8'sd128));
		send_req(req_play(4'd7, 7'd65, 8'd64, 32'd2000, 9'sd126, 8'sd64));
	endtask

	// retrigger, release with swap-in, release miss, zero duration
	task automatic test_retrigger_release();
		send_req(req_play(4'd15, 7'd127, 8'd200, 32'd40000, 9'sd127, -8'sd65));
		send_req(req_release(4'd0, 7'd0));
		send_req(req_release(4'd0, 7'd0));
		send_req(req_play(4'd7, 7'd64, 8'd9, 32'd0, 9'sd10, 8'sd0));
	endtask

	// fill the table, then steal: two entries tie for least time, first wins
	task automatic test_steal();
		send_req(req_play(4'd1, 7'd10, 8'd90, 32'd300, 9'sd50, 8'sd10));
		send_req(req_play(4'd1, 7'd11, 8'd91, 32'd700, 9'sd51, 8'sd11));
		send_req(req_play(4'd1, 7'd12, 8'd92, 32'd300, 9'sd52, 8'sd12));
		send_req(req_play(4'd1, 7'd13, 8'd93, 32'd5000, 9'sd53, 8'sd13));
		send_req(req_play(4'd1, 7'd14, 8'd94, 32'd900, 9'sd54, 8'sd14));
		send_req(req_play(4'd2, 7'd20, 8'd95, 32'd3000, 9'sd55, 8'sd15));
	endtask

	// zero frames, partial expiry with chained swap-ins, then a tick that
	// empties a full table in one go
	task automatic test_tick_expiry();
		send_req(req_tick(16'd0));
		send_req(req_tick(16'd900));
		send_req(req_play(4'd3, 7'd30, 8'd30, 32'd50, 9'sd0, 8'sd0));
		send_req(req_play(4'd3, 7'd31, 8'd31, 32'd60, 9'sd1, 8'sd1));
		send_req(req_play(4'd3, 7'd32, 8'd32, 32'd65535, 9'sd2, 8'sd2));
		send_req(req_tick(16'hFFFF));
	endtask

	// clear is silent, code 3 is ignored, and an empty table expires nothing
	task automatic test_clear_unused();
		send_req(req_play(4'd9, 7'd99, 8'd77, 32'd10, 9'sd33, 8'sd3));
		send_req(req_plain(CMD_CLEAR));
		send_req(req_plain(CMD_UNUSED));
		send_req(req_tick(16'hFFFF));
	endtask

	// clamp at zero, and at 255 where a full volume reads as "leave"
	task automatic test_volume_clamp();
		set_max_volume(8'd0);
		send_req(req_play(4'd4, 7'd44, 8'd100, 32'd500, 9'sd200, 8'sd5));
		set_max_volume(8'd255);
		send_req(req_play(4'd4, 7'd45, 8'd101, 32'd500, 9'sd255, 8'sd6));
		send_req(req_play(4'd4, 7'd46, 8'd102, 32'd500, 9'sd254, 8'sd7));
	endtask

	// ---------------------------------------------------------------
	// Random traffic in phases, each under its own max_volume and idling mix;
	// the last phase runs with no idling at all
	// ---------------------------------------------------------------
	task automatic test_random_traffic();
		note_req_t r;
		int phase;
		int counted;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				steady = 1'b1;
			case (phase)
				1: set_max_volume(8'd254);
				2: set_max_volume(8'd0);
				3: set_max_volume(8'd255);
				5: set_max_volume(VOL_RESET);
				default: set_max_volume(8'($urandom_range(254, 1)));
			endcase
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 60;
			endcase
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = random_req();
				if (r.cmd != CMD_UNUSED)
					counted++;
				// now and then let the block run completely dry
				if ($urandom_range(99) < 3)
					drain_events();
				send_req(r);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver side: random stall bursts, mix changes over time
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		stall_epoch <= stall_epoch + 1;
		if (stall_epoch % 256 == 255) begin
			case ($urandom_range(2))
				0: stall_pct <= 0;
				1: stall_pct <= 10;
				default: stall_pct <= 35;
			endcase
		end
		if (steady) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Result checker: every accepted beat against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected beat: kind %0d track %0d key %0d",
					event_kind, out_track, out_key);
				err_count++;
			end else begin
				event_due = pending_events.pop_front();
				check_field("event_kind", event_due.ev.kind, event_kind);
				check_field("out_track", event_due.ev.trk, out_track);
				check_field("out_key", event_due.ev.key, out_key);
				check_field("out_velocity", event_due.ev.vel, out_velocity);
				check_field("volume_code", event_due.ev.vol, volume_code);
				check_field("pan_code", event_due.ev.pan, pan_code);
				check_field("last", event_due.last, last);
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: too long with no beat on either channel
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_note_fields();
		test_retrigger_release();
		test_steal();
		test_tick_expiry();
		test_clear_unused();
		test_volume_clamp();
		test_random_traffic();
		// wait for the tail, then give stray beats a chance to show up
		drain_events();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
